// ----- hw/rtl/hll_pkg.sv -----
// ----------------------------------------------------------------------------
// hll_pkg: shared types and constants for the HyperLogLog sketch update
// Widths, limits and the work record passed from front to back.
// ----------------------------------------------------------------------------
package hll_pkg;

    localparam int MAX_PRECISION     = 14;
    localparam int SUM_FRACTION_BITS = 48;
    localparam int MIN_P             = 4;
    localparam int STORE_DEPTH       = 1 << MAX_PRECISION;
    localparam int IDX_W             = MAX_PRECISION;
    localparam int RANK_W            = 7;
    localparam int SUM_W             = 63;
    localparam int ZC_W              = 15;
    localparam int EST_W             = 40;
    localparam int ALPHA_W           = 48;
    localparam int HASH_W            = 64;
    localparam int CFG_DATA_W        = 48;
    localparam int CFG_IDX_W         = 2;
    localparam int DIV_STEPS         = 80;
    localparam int STEP_W            = 7;
    localparam int QDEPTH            = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd2;

    localparam logic [3:0]           PREC_RESET    = 4'd14;
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = 48'd12688364142592;
    localparam logic [EST_W-1:0]     EST_MAX       = {EST_W{1'b1}};

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [RANK_W-1:0] rank;
    } work_t;

    typedef struct packed {
        logic [EST_W-1:0] estimate;
        logic [ZC_W-1:0]  zero_count;
        logic [SUM_W-1:0] harmonic_sum;
    } result_t;

    // effective precision, clamped to MIN_P..MAX_PRECISION
    function automatic logic [4:0] eff_p(input logic [3:0] p);
        logic [4:0] r;
        r = {1'b0, p};
        if (r < 5'(MIN_P)) r = 5'(MIN_P);
        if (r > 5'(MAX_PRECISION)) r = 5'(MAX_PRECISION);
        return r;
    endfunction

    // 2^(SUM_FRACTION_BITS - r), zero above SUM_FRACTION_BITS
    function automatic logic [SUM_W-1:0] term_of(input logic [RANK_W-1:0] r);
        logic [SUM_W-1:0] t;
        t = '0;
        if (r <= RANK_W'(SUM_FRACTION_BITS))
            t[SUM_FRACTION_BITS - r] = 1'b1;
        return t;
    endfunction

endpackage

// ----- hw/rtl/hll_stream_if.sv -----
// ----------------------------------------------------------------------------
// hll_hash_if, hll_result_if: valid/ready channels
// Each carries one payload of parameterless type per transfer.
// ----------------------------------------------------------------------------
interface hll_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash;
    modport source (output valid, output hash, input ready);
    modport sink   (input valid, input hash, output ready);
endinterface

interface hll_result_if;
    logic         valid;
    logic         ready;
    logic [39:0]  estimate;
    logic [14:0]  zero_count;
    logic [62:0]  harmonic_sum;
    modport source (output valid, output estimate, output zero_count,
                    output harmonic_sum, input ready);
    modport sink   (input valid, input estimate, input zero_count,
                    input harmonic_sum, output ready);
endinterface

// ----- hw/rtl/hll_ram.sv -----
// ----------------------------------------------------------------------------
// hll_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module hll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ----- hw/rtl/hll_front.sv -----
// ----------------------------------------------------------------------------
// hll_front: hash classifier and work queue
// Extracts register index and rank, queues work for the back end.
// ----------------------------------------------------------------------------
module hll_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [3:0]            precision,
    input  logic                  hash_is_wide,
    input  logic                  flush,
    hll_hash_if.sink              in_ch,
    output logic                  wvalid,
    output hll_pkg::work_t        wdata,
    input  logic                  wready
);
    import hll_pkg::*;

    work_t           q_reg [QDEPTH];
    logic            rd_ptr_reg, wr_ptr_reg;
    logic [1:0]      cnt_reg;
    work_t           item;
    logic [4:0]      p;
    logic [6:0]      rest;
    logic [63:0]     h, hs, low;
    logic [6:0]      lz;
    logic            push, pop;

    assign p  = eff_p(precision);
    assign rest = (hash_is_wide ? 7'd64 : 7'd32) - {2'b0, p};
    assign h  = hash_is_wide ? in_ch.hash : {32'd0, in_ch.hash[31:0]};
    assign hs = h >> rest;
    // remaining bits left-aligned to bit 63, pad with ones past their end
    assign low = (h << (7'd64 - rest)) | ({64{1'b1}} >> rest);

    always_comb
    begin
        lz = 7'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if (lz == 7'(63 - i) && !low[i])
                lz = 7'(64 - i);
        end
        item.index = hs[IDX_W-1:0];
        item.rank  = (lz >= rest) ? rest + 7'd1 : lz + 7'd1;
    end

    assign in_ch.ready = (cnt_reg != 2'(QDEPTH)) && !flush;
    assign push   = in_ch.valid && in_ch.ready;
    assign wvalid = cnt_reg != 2'd0;
    assign wdata  = q_reg[rd_ptr_reg];
    assign pop    = wvalid && wready;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- hw/rtl/hll_back.sv -----
// ----------------------------------------------------------------------------
// hll_back: register update and estimate divider
// Read-modify-write of the rank store, sum upkeep, serial division.
// ----------------------------------------------------------------------------
module hll_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [3:0]            precision,
    input  logic [47:0]           alpha_m_squared,
    input  logic                  clear_req,
    output logic                  busy_clear,
    input  logic                  wvalid,
    input  hll_pkg::work_t        wdata,
    output logic                  wready,
    hll_result_if.source          out_ch
);
    import hll_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W:0]     clr_reg;
    work_t              cur_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [ZC_W-1:0]    zc_reg;
    logic [63:0]        rem_reg;
    logic [EST_W:0]     q_reg;
    logic [79:0]        num_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               sat_reg;
    result_t            res_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [RANK_W-1:0]  ram_wdata, ram_rdata;
    logic [4:0]         p;
    logic [64:0]        trial;
    logic [EST_W:0]     qn;
    logic [SUM_W-1:0]   new_sum;

    hll_ram #(.WIDTH(RANK_W), .DEPTH(STORE_DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign p = eff_p(precision);
    assign busy_clear = (state_reg == S_CLEAR);
    assign wready = (state_reg == S_IDLE) && !clear_req;
    assign new_sum = sum_reg - term_of(ram_rdata) + term_of(cur_reg.rank);
    assign trial = {rem_reg, num_reg[79]} - {2'b0, sum_reg};
    assign qn = {q_reg[EST_W-1:0], ~trial[64]};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = cur_reg.index;
        ram_wdata = cur_reg.rank;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[IDX_W-1:0];
                ram_wdata = '0;
            end
            S_IDLE:  ram_addr = wdata.index;
            S_UPD:   ram_we = cur_reg.rank > ram_rdata;
            default: ram_we = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == (IDX_W+1)'(STORE_DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (wvalid && wready) state_next = S_READ;
            S_READ:  state_next = S_UPD;
            S_UPD:   state_next = S_DIV;
            S_DIV:   if (step_reg == STEP_W'(DIV_STEPS - 1) || sat_reg) state_next = S_OUT;
            S_OUT:   if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (clear_req) state_next = S_CLEAR;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
            cur_reg <= wdata;
        if (state_reg == S_UPD)
        begin
            rem_reg  <= '0;
            q_reg    <= '0;
            num_reg  <= {alpha_m_squared, 32'd0};
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= trial[64] ? {rem_reg[62:0], num_reg[79]} : trial[63:0];
            q_reg   <= qn;
            num_reg <= {num_reg[78:0], 1'b0};
        end
        if (state_reg == S_DIV && state_next == S_OUT)
        begin
            res_reg.estimate     <= (sum_reg == '0 || sat_reg || qn[EST_W]) ? EST_MAX
                                    : qn[EST_W-1:0];
            res_reg.zero_count   <= zc_reg;
            res_reg.harmonic_sum <= sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            step_reg  <= '0;
            sat_reg   <= 1'b0;
            sum_reg   <= SUM_W'(64'(STORE_DEPTH) << SUM_FRACTION_BITS);
            zc_reg    <= ZC_W'(STORE_DEPTH);
        end
        else
        begin
            state_reg <= state_next;
            if (clear_req)
                clr_reg <= '0;
            else if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
                // take the register count from the precision now in force
                sum_reg <= SUM_W'(64'd1 << (6'(p) + 6'(SUM_FRACTION_BITS)));
                zc_reg  <= ZC_W'(16'd1 << p);
            end
            if (state_reg == S_UPD && !clear_req && cur_reg.rank > ram_rdata)
            begin
                sum_reg <= new_sum;
                if (ram_rdata == '0) zc_reg <= zc_reg - 1'b1;
            end
            if (state_reg == S_UPD)
            begin
                step_reg <= '0;
                sat_reg  <= 1'b0;
            end
            else if (state_reg == S_DIV)
            begin
                step_reg <= step_reg + 1'b1;
                sat_reg  <= sat_reg | qn[EST_W] | (sum_reg == '0);
            end
        end
    end

    assign out_ch.valid        = (state_reg == S_OUT);
    assign out_ch.estimate     = res_reg.estimate;
    assign out_ch.zero_count   = res_reg.zero_count;
    assign out_ch.harmonic_sum = res_reg.harmonic_sum;
endmodule

// ----- hw/rtl/hyperloglog_sketch_update.sv -----
// ----------------------------------------------------------------------------
// hyperloglog_sketch_update: HyperLogLog sketch with raw estimate
//
//   channel   dir  payload
//   in_ch     in   hash[63:0]
//   out_ch    out  estimate[39:0], zero_count[14:0], harmonic_sum[62:0]
//   cfg       in   cfg_we, cfg_index[1:0], cfg_data[47:0]
//
// Each item passes through a RAM read, an update, then an 80-step
// restoring divider (one quotient bit a cycle) that ends early on saturation.
// After reset and after any precision or width write, a clearing pass
// zeroes all 16384 entries of the rank store; no hash is accepted meanwhile.
// A two-entry queue lets the front accept while the back is dividing.
// ----------------------------------------------------------------------------
module hyperloglog_sketch_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hll_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hll_pkg::CFG_DATA_W-1:0] cfg_data,
    hll_hash_if.sink                      in_ch,
    hll_result_if.source                  out_ch
);
    import hll_pkg::*;

    logic [3:0]         precision_reg;
    logic               wide_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               clear_req;
    logic               busy_clear;
    logic               wvalid, wready;
    work_t              wdata;

    assign clear_req = cfg_we && (cfg_index == CFG_PRECISION || cfg_index == CFG_WIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            precision_reg <= PREC_RESET;
            wide_reg      <= 1'b0;
            alpha_reg     <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRECISION: precision_reg <= cfg_data[3:0];
                CFG_WIDE:      wide_reg      <= cfg_data[0];
                CFG_ALPHA:     alpha_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    hll_front u_front (
        .clk(clk), .rst_n(rst_n), .precision(precision_reg),
        .hash_is_wide(wide_reg), .flush(busy_clear || clear_req), .in_ch(in_ch),
        .wvalid(wvalid), .wdata(wdata), .wready(wready)
    );

    hll_back u_back (
        .clk(clk), .rst_n(rst_n), .precision(precision_reg),
        .alpha_m_squared(alpha_reg), .clear_req(clear_req), .busy_clear(busy_clear),
        .wvalid(wvalid), .wdata(wdata), .wready(wready), .out_ch(out_ch)
    );
endmodule
